FILE: hdl/tgr_pkg.sv
package tgr_pkg;

    // Default size of one font bank in bytes
    localparam int BANK_BYTES_DEF = 2048;

    // Item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Configuration register indexes
    localparam logic REG_DISPLAY_MODE = 1'b0;
    localparam logic REG_PCG_SELECT   = 1'b1;

    // Attribute byte bit positions
    localparam int ATTR_UPPER   = 3;
    localparam int ATTR_GRAPH   = 4;
    localparam int ATTR_REVERSE = 5;
    localparam int ATTR_SECRET  = 6;
    localparam int ATTR_UNDER   = 7;

    // Display mode bit positions
    localparam int MODE_SHORT_CELL = 0;
    localparam int MODE_WIDE80     = 1;

    // Last row of a cell in each cell mode
    localparam logic [3:0] ROW_LAST_SHORT = 4'd7;
    localparam logic [3:0] ROW_LAST_TALL  = 4'd9;
    localparam logic [3:0] ROW_TOP        = 4'd0;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  char_code;
        logic [7:0]  attr_byte;
        logic [3:0]  cell_row;
        logic [12:0] font_addr;
        logic [7:0]  font_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixels;
        logic [2:0]  color;
    } t_out_item;

    // Double every pixel of a row, MSB stays leftmost
    function automatic logic [15:0] widen_row(input logic [7:0] row);
        logic [15:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            acc[2*i +: 2] = {2{row[i]}};
        end
        return acc;
    endfunction

endpackage

FILE: hdl/text_glyph_row_generator_core.sv
// Text-mode glyph row generator. Each input beat either loads one byte of
// the font store (three banks: normal, graphic, programmable) or renders one
// pixel row of a character cell with its colour. The block is a four-stage
// pipeline (input register, address generation, font memory read, attribute
// and output register): it takes one item every cycle while the output is
// not stalled, and a render result is offered from the output register,
// where it waits while the output is stalled. The single-port font memory
// is read and written in the same stage, so a write is seen by every later
// render. Write beats and renders of rows beyond the cell height give no
// result beat. The font store is not cleared at reset; glyphs must be loaded
// before they are rendered. The user must write the configuration over the
// APB port only while no item is in flight; the block does not enforce it.
module text_glyph_row_generator_core #(
    parameter int BANK_BYTES = tgr_pkg::BANK_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tgr_pkg::t_in_item   i_in_item,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tgr_pkg::t_out_item  o_out_item,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tgr_pkg::*;

    localparam int STORE_BYTES = 3 * BANK_BYTES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int MW          = 15;

    localparam logic [MW-1:0] MOD_B4      = MW'(4 * BANK_BYTES);
    localparam logic [MW-1:0] MOD_B2      = MW'(2 * BANK_BYTES);
    localparam logic [MW-1:0] MOD_B1      = MW'(BANK_BYTES);
    localparam logic [MW-1:0] STORE_LIMIT = MW'(STORE_BYTES);
    localparam logic [AW-1:0] BASE_GRAPH  = AW'(BANK_BYTES);
    localparam logic [AW-1:0] BASE_PCG    = AW'(2 * BANK_BYTES);

    typedef struct packed {
        logic          render;
        logic          wr;
        logic [AW-1:0] addr;
        logic [7:0]    wdata;
        logic [7:0]    attr;
        logic          blank;
        logic          at_last;
        logic          at_top;
        logic          wide80;
    } t_s2;

    typedef struct packed {
        logic [7:0] attr;
        logic       blank;
        logic       at_last;
        logic       at_top;
        logic       wide80;
    } t_s3;

    logic [1:0]  r_display_mode;
    logic        r_pcg_select;

    logic        r_s1_vld;
    t_in_item    r_s1;
    logic        r_s2_vld;
    t_s2         r_s2;
    logic        r_s3_vld;
    t_s3         r_s3;
    logic [7:0]  r_rd_data;
    logic        r_s4_vld;
    t_out_item   r_s4;

    logic [7:0]  r_font_mem [0:STORE_BYTES-1];

    logic        en1;
    logic        en2;
    logic        en3;
    logic        en4;

    logic        n_s2_vld;
    t_s2         n_s2;
    t_out_item   n_s4;

    // Configuration registers, decoded on the word address bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode <= 2'd0;
            r_pcg_select   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_DISPLAY_MODE: r_display_mode <= pwdata[1:0];
                REG_PCG_SELECT:   r_pcg_select   <= pwdata[0];
                default:          r_pcg_select   <= r_pcg_select;
            endcase
        end
    end

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_DISPLAY_MODE: prdata = {30'd0, r_display_mode};
            REG_PCG_SELECT:   prdata = {31'd0, r_pcg_select};
            default:          prdata = '0;
        endcase
    end

    // A stage advances when it is empty or the next one advances
    assign en4        = !r_s4_vld || i_out_ready;
    assign en3        = !r_s3_vld || en4;
    assign en2        = !r_s2_vld || en3;
    assign en1        = !r_s1_vld || en2;
    assign o_in_ready = en1;

    // Stage 1: capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en1) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_s1 <= i_in_item;
        end
    end

    // Stage 2: pick the bank, fold the glyph offset into it, classify the row
    always_comb begin
        logic          short_cell;
        logic [3:0]    last_row;
        logic [2:0]    glyph_row;
        logic [MW-1:0] off;
        logic [AW-1:0] base;

        short_cell = r_display_mode[MODE_SHORT_CELL];
        last_row   = short_cell ? ROW_LAST_SHORT : ROW_LAST_TALL;
        glyph_row  = short_cell ? r_s1.cell_row[2:0] : 3'(r_s1.cell_row - 4'd1);

        // offset modulo the bank size by restoring subtraction (quotient < 8)
        off = {(MW-11)'(0), r_s1.char_code, glyph_row};
        if (off >= MOD_B4) begin
            off = off - MOD_B4;
        end
        if (off >= MOD_B2) begin
            off = off - MOD_B2;
        end
        if (off >= MOD_B1) begin
            off = off - MOD_B1;
        end

        priority if (r_s1.attr_byte[ATTR_GRAPH]) begin
            base = BASE_GRAPH;
        end else if (r_pcg_select) begin
            base = BASE_PCG;
        end else begin
            base = '0;
        end

        n_s2.render  = (r_s1.opcode == OP_RENDER);
        n_s2.wr      = (r_s1.opcode == OP_WRITE)
                       && ({(MW-13)'(0), r_s1.font_addr} < STORE_LIMIT);
        n_s2.addr    = (r_s1.opcode == OP_WRITE) ? AW'(r_s1.font_addr)
                                                 : base + AW'(off);
        n_s2.wdata   = r_s1.font_data;
        n_s2.attr    = r_s1.attr_byte;
        n_s2.blank   = !short_cell
                       && (r_s1.cell_row == ROW_TOP || r_s1.cell_row == ROW_LAST_TALL);
        n_s2.at_last = (r_s1.cell_row == last_row);
        n_s2.at_top  = (r_s1.cell_row == ROW_TOP);
        n_s2.wide80  = r_display_mode[MODE_WIDE80];

        // drop renders of rows beyond the cell
        n_s2_vld = r_s1_vld && ((r_s1.opcode == OP_WRITE) || (r_s1.cell_row <= last_row));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en2) begin
            r_s2_vld <= n_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && n_s2_vld) begin
            r_s2 <= n_s2;
        end
    end

    // Stage 3: font memory, one access per item
    always_ff @(posedge i_clk) begin
        if (en3) begin
            if (r_s2_vld && r_s2.wr) begin
                r_font_mem[r_s2.addr] <= r_s2.wdata;
            end
            r_rd_data <= r_font_mem[r_s2.addr];
        end
    end

    // only renders go on past the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en3) begin
            r_s3_vld <= r_s2_vld && r_s2.render;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_s2_vld) begin
            r_s3.attr    <= r_s2.attr;
            r_s3.blank   <= r_s2.blank;
            r_s3.at_last <= r_s2.at_last;
            r_s3.at_top  <= r_s2.at_top;
            r_s3.wide80  <= r_s2.wide80;
        end
    end

    // Stage 4: blank, apply secret, underline, upper line, reverse; widen the row outside 80-column mode
    always_comb begin
        logic [7:0] bits;

        bits = r_s3.blank ? 8'h00 : r_rd_data;
        if (r_s3.attr[ATTR_SECRET]) begin
            bits = 8'h00;
        end
        if (r_s3.attr[ATTR_UNDER] && r_s3.at_last) begin
            bits = 8'hff;
        end
        if (r_s3.attr[ATTR_UPPER] && r_s3.at_top) begin
            bits = 8'hff;
        end
        if (r_s3.attr[ATTR_REVERSE]) begin
            bits = ~bits;
        end

        n_s4.pixels = r_s3.wide80 ? {8'h00, bits} : widen_row(bits);
        n_s4.color  = r_s3.attr[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (en4) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_s3_vld) begin
            r_s4 <= n_s4;
        end
    end

    assign o_out_valid = r_s4_vld;
    assign o_out_item  = r_s4;

    // An empty output register always lets a new beat in
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready although the output register is empty");

    // A stalled output keeps the render waiting behind it
    a_stall_keeps_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld && o_out_valid && !i_out_ready |=> r_s3_vld)
        else $error("render in the memory stage lost during a stall");

    // Pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_s3_vld && !r_s2_vld && !r_s1_vld)
        else $error("pipeline holds an item after reset");

    // In 80-column mode the upper pixel byte is zero
    a_narrow_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_display_mode[MODE_WIDE80] |-> o_out_item.pixels[15:8] == 8'h00)
        else $error("upper pixel byte set in 80-column mode");

endmodule

FILE: tb/text_glyph_row_generator_core_tb.sv
`timescale 1ns / 100ps

module text_glyph_row_generator_core_tb;
    import tgr_pkg::*;

    localparam int BANK          = BANK_BYTES_DEF;
    localparam int STORE         = 3 * BANK;
    localparam int BANK_NORMAL   = 0;
    localparam int BANK_GRAPHIC  = 1;
    localparam int BANK_PCG      = 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 200;

    localparam logic [2:0] ADDR_MODE = {REG_DISPLAY_MODE, 2'b00};
    localparam logic [2:0] ADDR_PCG  = {REG_PCG_SELECT, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the font store and of the registers
    logic [7:0]  font_img [STORE];
    bit          font_known [STORE];
    logic [1:0]  mode_cfg;
    logic        pcg_cfg;

    t_out_item   pending_rows [$];
    int          mismatches;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          hold_asks;
    int          hold_seen;
    int          hold_left;
    int          cycle_count;

    text_glyph_row_generator_core #(
        .BANK_BYTES(BANK)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch %s: expected %h, got %h", what, want, got);
        end
    endtask

    // Last row of a cell in the current mode
    function automatic logic [3:0] row_last();
        return mode_cfg[MODE_SHORT_CELL] ? ROW_LAST_SHORT : ROW_LAST_TALL;
    endfunction

    // Font byte that a render reads, if it reads one at all
    function automatic bit glyph_index(input t_in_item it, output int idx);
        int   bank;
        int   glyph_row;
        logic short_cell;
        short_cell = mode_cfg[MODE_SHORT_CELL];
        idx = 0;
        if (it.cell_row > row_last()) begin
            return 1'b0;
        end
        if (!short_cell && (it.cell_row == ROW_TOP || it.cell_row == ROW_LAST_TALL)) begin
            return 1'b0;
        end
        glyph_row = short_cell ? int'(it.cell_row) : int'(it.cell_row) - 1;
        if (it.attr_byte[ATTR_GRAPH]) begin
            bank = BANK_GRAPHIC;
        end else if (pcg_cfg) begin
            bank = BANK_PCG;
        end else begin
            bank = BANK_NORMAL;
        end
        idx = bank * BANK + (int'(it.char_code) * 8 + glyph_row) % BANK;
        return 1'b1;
    endfunction

    function automatic logic [15:0] double_pixels(input logic [7:0] row);
        logic [15:0] px;
        px = '0;
        for (int b = 7; b >= 0; b--) begin
            px = {px[13:0], row[b], row[b]};
        end
        return px;
    endfunction

    // Update the shadow store or queue the pixel row a render yields
    task automatic predict_glyph_row(input t_in_item it);
        int          idx;
        logic [7:0]  bits;
        logic [3:0]  last;
        t_out_item   row_out;
        if (it.opcode == OP_WRITE) begin
            if (it.font_addr < STORE) begin
                font_img[it.font_addr]   = it.font_data;
                font_known[it.font_addr] = 1'b1;
            end
            return;
        end
        last = row_last();
        if (it.cell_row > last) begin
            return;
        end
        bits = glyph_index(it, idx) ? font_img[idx] : 8'h00;
        if (it.attr_byte[ATTR_SECRET]) begin
            bits = 8'h00;
        end
        if (it.attr_byte[ATTR_UNDER] && it.cell_row == last) begin
            bits = 8'hFF;
        end
        if (it.attr_byte[ATTR_UPPER] && it.cell_row == ROW_TOP) begin
            bits = 8'hFF;
        end
        if (it.attr_byte[ATTR_REVERSE]) begin
            bits = ~bits;
        end
        row_out.pixels = mode_cfg[MODE_WIDE80] ? {8'h00, bits} : double_pixels(bits);
        row_out.color  = it.attr_byte[2:0];
        pending_rows.push_back(row_out);
    endtask

    // Offer one beat, idling at random first, and hold it until taken
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        predict_glyph_row(it);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        it.opcode    = 1'($urandom_range(1));
        it.char_code = 8'($urandom_range(255));
        it.attr_byte = 8'($urandom_range(255));
        it.cell_row  = 4'($urandom_range(15));
        it.font_addr = 13'($urandom_range(8191));
        it.font_data = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic t_in_item make_write(input int addr, input logic [7:0] data);
        t_in_item it;
        it           = random_item();
        it.opcode    = OP_WRITE;
        it.font_addr = 13'(addr);
        it.font_data = data;
        return it;
    endfunction

    function automatic t_in_item make_render(input logic [7:0] code, input logic [7:0] attr,
                                             input logic [3:0] row);
        t_in_item it;
        it           = random_item();
        it.opcode    = OP_RENDER;
        it.char_code = code;
        it.attr_byte = attr;
        it.cell_row  = row;
        return it;
    endfunction

    // Load the glyph byte first if the render would read an empty location
    task automatic send_render(input t_in_item it);
        int idx;
        if (glyph_index(it, idx) && !font_known[idx]) begin
            send_item(make_write(idx, 8'($urandom_range(255))));
        end
        send_item(it);
    endtask

    // Drop valid and hold until every row has come back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_reg_check(input string name, input logic [2:0] addr,
                                  input logic [31:0] want);
        logic [31:0] rd;
        apb_xfer(1'b0, addr, 32'd0, rd);
        if (rd !== want) begin
            report_mismatch(name, want, rd);
        end
    endtask

    // Reprogram both registers once the pipeline is empty
    task automatic set_display(input logic [1:0] mode, input logic pcg);
        logic [31:0] rd;
        wait_results_done();
        apb_xfer(1'b1, ADDR_MODE, {30'd0, mode}, rd);
        mode_cfg = mode;
        apb_xfer(1'b1, ADDR_PCG, {31'd0, pcg}, rd);
        pcg_cfg = pcg;
        read_reg_check("display_mode", ADDR_MODE, {30'd0, mode});
        read_reg_check("pcg_select", ADDR_PCG, {31'd0, pcg});
    endtask

    // Take result beats and compare them with the oldest predicted row
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_rows.size() == 0) begin
                    report_mismatch("unexpected beat", 32'd0, {13'd0, o_out_item});
                end else begin
                    want = pending_rows.pop_front();
                    if (o_out_item.pixels !== want.pixels) begin
                        report_mismatch("pixels", {16'd0, want.pixels},
                                        {16'd0, o_out_item.pixels});
                    end
                    if (o_out_item.color !== want.color) begin
                        report_mismatch("color", {29'd0, want.color},
                                        {29'd0, o_out_item.color});
                    end
                end
            end
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Field extremes, every attribute and the cell edge cases
    task automatic test_directed();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_item(make_write(0, 8'hA5));
        send_item(make_write(STORE - 1, 8'h81));
        send_item(make_write(BANK + 8, 8'h3C));
        send_item(make_write(BANK - 1, 8'h18));
        // addresses past the store must be ignored
        send_item(make_write(8191, 8'h00));
        send_item(make_write(STORE, 8'hFF));
        send_render(make_render(8'h00, 8'h07, 4'd1));
        send_render(make_render(8'hFF, 8'h00, 4'd8));
        send_render(make_render(8'h00, 8'h08, ROW_TOP));
        send_render(make_render(8'h00, 8'h80, ROW_LAST_TALL));
        send_render(make_render(8'h00, 8'h00, ROW_LAST_TALL));
        send_render(make_render(8'h00, 8'h20, 4'd1));
        send_render(make_render(8'h00, 8'h60, 4'd1));
        send_render(make_render(8'h00, 8'hC0, ROW_LAST_TALL));
        send_render(make_render(8'h01, 8'h10, 4'd1));
        send_render(make_render(8'h00, 8'h00, 4'd10));
        send_render(make_render(8'h00, 8'hFF, 4'd15));
        // short cells, 80 columns, programmable bank
        set_display(2'd3, 1'b1);
        send_render(make_render(8'hFF, 8'h00, ROW_LAST_SHORT));
        send_render(make_render(8'hFF, 8'hA8, ROW_LAST_SHORT));
        send_render(make_render(8'hFF, 8'h08, ROW_TOP));
        send_render(make_render(8'hFF, 8'h10, ROW_LAST_SHORT));
        send_render(make_render(8'h80, 8'hFF, 4'd3));
        send_render(make_render(8'h00, 8'h00, 4'd8));
    endtask

    // Random writes and renders across all four display modes, with the bank select alternating
    task automatic test_random(input int snd_pct, input int rcv_pct, input int phase);
        t_in_item it;
        for (int setting = 0; setting < 4; setting++) begin
            set_display(2'(setting), 1'((setting + phase) % 2));
            snd_idle_pct = snd_pct;
            rcv_idle_pct = rcv_pct;
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                it = random_item();
                if ($urandom_range(99) < 20) begin
                    it.opcode = OP_WRITE;
                    if ($urandom_range(19) == 0) begin
                        it.font_addr = 13'($urandom_range(8191, STORE));
                    end else begin
                        it.font_addr = 13'($urandom_range(STORE - 1));
                    end
                    send_item(it);
                end else begin
                    it.opcode = OP_RENDER;
                    // reuse a small set of glyphs so rendered bytes get rewritten
                    if ($urandom_range(1) == 0) begin
                        it.char_code = {4'hC, 4'($urandom_range(15))};
                    end
                    if ($urandom_range(9) != 0) begin
                        it.cell_row = 4'($urandom_range(int'(row_last())));
                    end
                    send_render(it);
                end
            end
        end
    endtask

    // Stall the result side long enough to fill the pipeline
    task automatic test_receiver_hold();
        t_in_item it;
        set_display(2'd0, 1'b0);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_asks++;
        for (int n = 0; n < 48; n++) begin
            it = random_item();
            it.opcode   = OP_RENDER;
            it.cell_row = 4'($urandom_range(int'(row_last())));
            send_render(it);
        end
        wait_results_done();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_ready <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        mode_cfg     = 2'd0;
        pcg_cfg      = 1'b0;
        mismatches   = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_asks    = 0;
        hold_seen    = 0;
        hold_left    = 0;
        cycle_count  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(30, 55, 0);
        test_receiver_hold();
        test_random(55, 30, 1);
        test_random(0, 0, 0);

        wait_results_done();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
